// ===== hdl/pfb_pkg.sv =====
// Package for the pixel fragment back end.
// Holds frame size, memory address width, register indexes and color constants.
// No dependencies.
package pfb_pkg;

	localparam int VIEW_WIDTH  = 256;
	localparam int VIEW_HEIGHT = 256;
	localparam int PIX_COUNT   = VIEW_WIDTH * VIEW_HEIGHT;
	localparam int ADDR_W      = $clog2(PIX_COUNT);
	localparam int CLR_W       = ADDR_W + 1;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_KEY   = 3'd1;
	localparam logic [2:0] REG_FLAT  = 3'd2;
	localparam logic [2:0] REG_FOGC  = 3'd3;
	localparam logic [2:0] REG_NEAR  = 3'd4;
	localparam logic [2:0] REG_FAR   = 3'd5;

	localparam logic [23:0] RGB_MASK  = 24'hFFFFFF;
	localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
	localparam logic [23:0] FAR_DEPTH = 24'hFFFFFF;
	localparam logic [8:0]  ONE_SHADE = 9'd256;

	typedef logic [2:0][8:0] chan9_t;

endpackage

// ===== hdl/pixel_fragment_backend.sv =====
// Pixel fragment back end: depth test, key, shade, fog, blend and write-back.
// Depth and color live in two synchronous memories; fog uses a bit-serial divider.
// A clear or dropped fragment goes from S_READ straight to S_FIN; a shaded one passes
// S_MIX and S_MUL first, and a fogged one also S_DIV before them. One item is in work at
// a time: a new beat is taken once the last is done, later still while out_ready is low.
// After reset a clearing pass sets every depth to farthest; no beat is taken before it ends.
module pixel_fragment_backend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [23:0] depth,
	input  logic [8:0]  shade_red,
	input  logic [8:0]  shade_green,
	input  logic [8:0]  shade_blue,
	input  logic        textured,
	input  logic [23:0] texel_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pixel_written,
	output logic [7:0]  out_x,
	output logic [7:0]  out_y,
	output logic [23:0] out_color
);
	import pfb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MIX  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [3:0]  mode_q;
	logic [23:0] key_q, flat_q, fogc_q, near_q, far_q;

	logic [2:0]  state_q;
	logic [CLR_W-1:0] clr_cnt_q;
	logic        clr_done;

	logic        op_q, tex_q, inview_q;
	logic [7:0]  x_q, y_q;
	logic [23:0] z_q, texel_q;
	chan9_t      shade_q, m_q;
	logic [ADDR_W-1:0] addr_q, in_addr;
	logic [23:0] dep_rd_q, col_rd_q;
	logic [24:0] rem_q;
	logic [7:0]  quo_q;
	logic [3:0]  div_cnt_q;
	logic [8:0]  k_q;
	logic [23:0] color_q;
	logic        wr_q;

	logic        accept, finish;
	logic        dep_we, col_we;
	logic [ADDR_W-1:0] dep_waddr;
	logic [23:0] dep_wdata;
	logic [24:0] rem_sh;
	logic [23:0] tsel;
	logic [23:0] new_color;
	chan9_t      fogf, m_next;

	logic [23:0] depth_mem [PIX_COUNT];
	logic [23:0] color_mem [PIX_COUNT];

	assign clr_done = clr_cnt_q[CLR_W-1];
	assign in_ready = (state_q == S_IDLE) && clr_done;
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == S_FIN) && (!out_valid || out_ready);
	assign in_addr  = ADDR_W'(32'(pixel_y) * VIEW_WIDTH + 32'(pixel_x));

	assign dep_we    = !clr_done || (finish && wr_q);
	assign dep_waddr = clr_done ? addr_q : clr_cnt_q[ADDR_W-1:0];
	assign dep_wdata = !clr_done ? FAR_DEPTH : (op_q ? FAR_DEPTH : z_q);
	assign col_we    = finish && wr_q;

	always_ff @(posedge clk) begin
		if (dep_we) begin
			depth_mem[dep_waddr] <= dep_wdata;
		end
		if (accept) begin
			dep_rd_q <= depth_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			color_mem[addr_q] <= color_q;
		end
		if (accept) begin
			col_rd_q <= color_mem[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			key_q  <= '0;
			flat_q <= RGB_MASK;
			fogc_q <= RGB_MASK;
			near_q <= 24'h800000;
			far_q  <= RGB_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[3:0];
				REG_KEY:  key_q  <= cfg_data;
				REG_FLAT: flat_q <= cfg_data;
				REG_FOGC: fogc_q <= cfg_data;
				REG_NEAR: near_q <= cfg_data;
				REG_FAR:  far_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tsel   = tex_q ? texel_q : flat_q;
	assign rem_sh = {rem_q[23:0], 1'b0};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fogf[c] = {1'b0, fogc_q[c*8 +: 8]} + 9'(fogc_q[c*8+7]);
			if (mode_q[1]) begin
				m_next[c] = 9'((18'(shade_q[c]) * 18'(ONE_SHADE - k_q)
					+ 18'(fogf[c]) * 18'(k_q) + 18'd128) >> 8);
			end else begin
				m_next[c] = shade_q[c];
			end
		end
	end

	always_comb begin
		logic [23:0] raw;
		logic [16:0] p;
		raw = '0;
		for (int c = 0; c < 3; c++) begin
			p = 17'(m_q[c]) * 17'(tsel[c*8 +: 8]);
			raw[c*8 +: 8] = p[15:8];
		end
		if (mode_q[2]) begin
			new_color = ((raw >> 1) & HALF_MASK) + ((col_rd_q >> 1) & HALF_MASK);
		end else begin
			new_color = raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (!clr_done) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (op_q || !inview_q || !(dep_rd_q > z_q)
						|| (tex_q && mode_q[0] && texel_q == key_q)) begin
						state_q <= S_FIN;
					end else if (mode_q[1] && z_q > near_q && z_q < far_q) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_MIX;
					end
				end
				S_DIV: begin
					if (div_cnt_q == 4'd7) begin
						state_q <= S_MIX;
					end
				end
				S_MIX: state_q <= S_MUL;
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (finish) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			x_q      <= pixel_x;
			y_q      <= pixel_y;
			z_q      <= depth;
			tex_q    <= textured;
			texel_q  <= texel_color;
			addr_q   <= in_addr;
			inview_q <= (32'(pixel_x) < VIEW_WIDTH) && (32'(pixel_y) < VIEW_HEIGHT);
			shade_q[0] <= shade_blue  > ONE_SHADE ? ONE_SHADE : shade_blue;
			shade_q[1] <= shade_green > ONE_SHADE ? ONE_SHADE : shade_green;
			shade_q[2] <= shade_red   > ONE_SHADE ? ONE_SHADE : shade_red;
		end
		unique case (state_q)
			S_READ: begin
				if (!mode_q[3]) begin
					shade_q <= {3{ONE_SHADE}};
				end
				k_q       <= (z_q <= near_q || !mode_q[1]) ? 9'd0 : ONE_SHADE;
				rem_q     <= {1'b0, z_q - near_q};
				quo_q     <= '0;
				div_cnt_q <= '0;
				wr_q      <= inview_q && op_q;
				color_q   <= (inview_q && op_q) ? texel_q : 24'd0;
			end
			S_DIV: begin
				if (rem_sh >= {1'b0, far_q - near_q}) begin
					rem_q <= rem_sh - {1'b0, far_q - near_q};
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[6:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 4'd7) begin
					k_q <= {1'b0, quo_q[6:0],
						rem_sh >= {1'b0, far_q - near_q}};
				end
			end
			S_MIX: m_q <= m_next;
			S_MUL: begin
				color_q <= new_color;
				wr_q    <= 1'b1;
			end
			default: ;
		endcase
		if (finish) begin
			pixel_written <= wr_q;
			out_x         <= x_q;
			out_y         <= y_q;
			out_color     <= color_q;
		end
	end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for pixel_fragment_backend: random and directed fragments and clears,
// with predicted results compared beat by beat against the block's output channel.
// Depends on pfb_pkg and the block's RTL.
module tb;
	import pfb_pkg::*;

	typedef struct {
		bit        op;
		bit [7:0]  x;
		bit [7:0]  y;
		bit [23:0] z;
		bit [8:0]  sr;
		bit [8:0]  sg;
		bit [8:0]  sb;
		bit        tx;
		bit [23:0] texel;
	} frag_t;

	typedef struct {
		bit        wr;
		bit [7:0]  x;
		bit [7:0]  y;
		bit [23:0] color;
	} pix_t;

	localparam int STALL_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = REG_MODE;
	logic [23:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        operation = 0;
	logic [7:0]  pixel_x = 0;
	logic [7:0]  pixel_y = 0;
	logic [23:0] depth = 0;
	logic [8:0]  shade_red = 0;
	logic [8:0]  shade_green = 0;
	logic [8:0]  shade_blue = 0;
	logic        textured = 0;
	logic [23:0] texel_color = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        pixel_written;
	logic [7:0]  out_x;
	logic [7:0]  out_y;
	logic [23:0] out_color;

	pixel_fragment_backend u_dut (.*);

	always #4 clk = ~clk;

	// Shadow registers and frame memories of the predictor.
	bit [3:0]  mode_r = 0;
	bit [23:0] key_r = 0;
	bit [23:0] flat_r = RGB_MASK;
	bit [23:0] fogc_r = RGB_MASK;
	bit [23:0] near_r = 24'h800000;
	bit [23:0] far_r = RGB_MASK;
	bit [23:0] zbuf [PIX_COUNT];
	bit [23:0] cbuf [PIX_COUNT];
	bit        bg_set [PIX_COUNT];

	frag_t pending_frags[$];
	pix_t  expected_pixels[$];
	int    errors = 0;
	int    issued = 0;
	int    frags_taken = 0;
	int    pixels_taken = 0;
	bit    calm = 0;

	initial begin
		for (int i = 0; i < PIX_COUNT; i++) begin
			zbuf[i] = FAR_DEPTH;
			bg_set[i] = 0;
		end
	end

	function automatic bit [8:0] fog_weight(bit [23:0] z);
		longint unsigned num;
		if (z <= near_r) return 0;
		if (z >= far_r) return 256;
		num = longint'(z - near_r) << 8;
		return 9'(num / longint'(far_r - near_r));
	endfunction

	function automatic bit [7:0] shade_chan(bit [8:0] s, bit [7:0] fc, bit [8:0] k, bit fog,
			bit [7:0] t);
		int unsigned m;
		int unsigned f;
		m = (s > 256) ? 256 : s;
		if (fog) begin
			f = fc + (fc >> 7);
			m = (m * (256 - k) + f * k + 128) >> 8;
		end
		return 8'(((m * t) >> 8) & 8'hFF);
	endfunction

	function automatic pix_t shade_pixel(frag_t f);
		pix_t r;
		int unsigned idx;
		bit [23:0] t;
		bit [23:0] c;
		bit [8:0] k;
		bit [8:0] sr, sg, sb;
		bit fog;
		r.wr = 0;
		r.x = f.x;
		r.y = f.y;
		r.color = 0;
		idx = f.y * VIEW_WIDTH + f.x;
		if (f.op) begin
			zbuf[idx] = FAR_DEPTH;
			cbuf[idx] = f.texel;
			r.wr = 1;
			r.color = f.texel;
		end else if (zbuf[idx] > f.z && !(f.tx && mode_r[0] && f.texel == key_r)) begin
			t = f.tx ? f.texel : flat_r;
			fog = mode_r[1];
			k = fog ? fog_weight(f.z) : 0;
			sr = mode_r[3] ? f.sr : ONE_SHADE;
			sg = mode_r[3] ? f.sg : ONE_SHADE;
			sb = mode_r[3] ? f.sb : ONE_SHADE;
			c = {shade_chan(sr, fogc_r[23:16], k, fog, t[23:16]),
				shade_chan(sg, fogc_r[15:8], k, fog, t[15:8]),
				shade_chan(sb, fogc_r[7:0], k, fog, t[7:0])};
			if (mode_r[2])
				c = ((c >> 1) & HALF_MASK) + ((cbuf[idx] >> 1) & HALF_MASK);
			cbuf[idx] = c;
			zbuf[idx] = f.z;
			r.wr = 1;
			r.color = c;
		end
		return r;
	endfunction

	// Input side: predict each accepted beat; output side: compare with the oldest prediction.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_pixels.push_back(shade_pixel('{operation, pixel_x, pixel_y, depth,
				shade_red, shade_green, shade_blue, textured, texel_color}));
			frags_taken <= frags_taken + 1;
		end
		if (out_valid && out_ready) begin
			pixels_taken <= pixels_taken + 1;
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, actual wr=%0d x=%0d y=%0d color=%06h", $time,
					pixel_written, out_x, out_y, out_color);
			end else begin
				pix_t e;
				e = expected_pixels.pop_front();
				if (pixel_written !== e.wr || out_x !== e.x || out_y !== e.y
						|| out_color !== e.color) begin
					errors++;
					$display("%0t: mismatch, expected %0d %0d %0d %06h, actual %0d %0d %0d %06h",
						$time, e.wr, e.x, e.y, e.color,
						pixel_written, out_x, out_y, out_color);
				end
			end
		end
	end

	int send_gap = 0;
	always @(negedge clk) begin
		frag_t f;
		if (!in_valid || frags_taken == issued) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 14);
				in_valid <= 0;
			end else if (pending_frags.size() != 0) begin
				f = pending_frags.pop_front();
				operation <= f.op;
				pixel_x <= f.x;
				pixel_y <= f.y;
				depth <= f.z;
				shade_red <= f.sr;
				shade_green <= f.sg;
				shade_blue <= f.sb;
				textured <= f.tx;
				texel_color <= f.texel;
				issued <= issued + 1;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	int hold_left = 0;
	bit long_done = 0;
	always @(negedge clk) begin
		if (!long_done && pixels_taken >= 300) begin
			long_done <= 1;
			hold_left <= LONG_HOLD;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			hold_left <= $urandom_range(0, 14);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, bit [23:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_MODE: mode_r = val[3:0];
			REG_KEY:  key_r = val;
			REG_FLAT: flat_r = val;
			REG_FOGC: fogc_r = val;
			REG_NEAR: near_r = val;
			REG_FAR:  far_r = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		wait (pending_frags.size() == 0 && !in_valid && expected_pixels.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic queue_frag(bit op, bit [7:0] x, bit [7:0] y, bit [23:0] z, bit [8:0] s,
			bit tx, bit [23:0] texel);
		frag_t f;
		f = '{op, x, y, z, s, s, s, tx, texel};
		// A blend must never read a pixel that holds no color yet.
		if (!op && mode_r[2] && !bg_set[y * VIEW_WIDTH + x])
			f.op = 1;
		if (f.op)
			bg_set[y * VIEW_WIDTH + x] = 1;
		pending_frags.push_back(f);
	endtask

	task automatic queue_random(int n);
		frag_t f;
		for (int i = 0; i < n; i++) begin
			f.op = ($urandom_range(0, 5) == 0);
			f.x = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 7));
			f.y = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0: f.z = 0;
				1: f.z = FAR_DEPTH;
				2: f.z = 24'(near_r + $urandom_range(0, 4095));
				default: f.z = 24'($urandom);
			endcase
			f.sr = ($urandom_range(0, 3) == 0) ? ONE_SHADE : 9'($urandom_range(0, 511));
			f.sg = ($urandom_range(0, 3) == 0) ? ONE_SHADE : 9'($urandom_range(0, 511));
			f.sb = ($urandom_range(0, 3) == 0) ? ONE_SHADE : 9'($urandom_range(0, 511));
			f.tx = 1'($urandom);
			f.texel = ($urandom_range(0, 3) == 0) ? key_r : 24'($urandom);
			if (!f.op && mode_r[2] && !bg_set[f.y * VIEW_WIDTH + f.x])
				f.op = 1;
			if (f.op)
				bg_set[f.y * VIEW_WIDTH + f.x] = 1;
			pending_frags.push_back(f);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;

		// Reset settings: no fog, no blend, white shade.
		queue_frag(0, 0, 0, 0, 0, 1, 24'h123456);
		queue_frag(0, 0, 0, 0, 0, 1, 24'h654321);
		queue_frag(1, 255, 255, 0, 0, 0, RGB_MASK);
		queue_frag(0, 255, 255, FAR_DEPTH, 256, 0, 0);
		queue_frag(0, 255, 255, 24'hFFFFFE, 256, 0, 0);
		queue_frag(1, 0, 0, 0, 0, 0, 0);
		queue_frag(0, 0, 0, 24'h7FFFFF, 511, 0, 0);
		queue_random(100);
		settle();

		// Everything on; shade above one, keyed texel, fog extremes, blend.
		write_reg(REG_MODE, 4'hF);
		write_reg(REG_KEY, 24'hFF00FF);
		write_reg(REG_FLAT, 24'h808080);
		write_reg(REG_FOGC, 24'h00FF80);
		write_reg(REG_NEAR, 24'h100000);
		write_reg(REG_FAR, 24'hF00000);
		queue_frag(1, 3, 3, 0, 0, 0, 24'hA0B0C0);
		queue_frag(0, 3, 3, 24'h0FFFFF, 511, 1, 24'hFFFFFF);
		queue_frag(0, 3, 3, 24'h0FFFFE, 300, 1, 24'hFF00FF);
		queue_frag(0, 3, 3, 24'h800000, 128, 0, 24'hFF00FF);
		queue_frag(0, 3, 3, 24'h000000, 256, 1, 24'h010203);
		queue_frag(1, 4, 4, 0, 0, 0, 24'h000000);
		queue_frag(0, 4, 4, 24'hF00000, 0, 1, 24'hFFFFFF);
		queue_frag(1, 4, 4, 0, 0, 0, 24'hFFFFFF);
		queue_frag(0, 4, 4, 24'hEFFFFF, 256, 1, 24'hFFFFFF);
		queue_random(120);
		settle();

		// Empty fog range, fog alone.
		write_reg(REG_MODE, 4'h2);
		write_reg(REG_NEAR, RGB_MASK);
		write_reg(REG_FAR, 0);
		queue_frag(1, 9, 9, 0, 0, 0, 24'h111111);
		queue_frag(0, 9, 9, RGB_MASK - 1, 0, 1, 24'hFFFFFF);
		queue_random(120);
		settle();

		write_reg(REG_NEAR, 0);
		write_reg(REG_FAR, 1);
		write_reg(REG_MODE, 4'hB);
		write_reg(REG_KEY, RGB_MASK);
		write_reg(REG_FOGC, 0);
		write_reg(REG_FLAT, 0);
		queue_random(120);
		settle();

		for (int p = 0; p < 5; p++) begin
			write_reg(REG_MODE, 24'($urandom_range(0, 15)));
			write_reg(REG_KEY, 24'($urandom));
			write_reg(REG_FLAT, 24'($urandom));
			write_reg(REG_FOGC, 24'($urandom));
			write_reg(REG_NEAR, 24'($urandom));
			write_reg(REG_FAR, 24'($urandom));
			queue_random(110);
			settle();
		end

		write_reg(REG_MODE, 4'hE);
		write_reg(REG_NEAR, 24'h400000);
		write_reg(REG_FAR, 24'hC00000);
		calm = 1;
		queue_random(110);
		settle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
